[sv/jmse_pkg.sv]
// Package with the shared types, codes and signature tables of the JPEG metadata extractor.
package jmse_pkg;

   localparam int SIG_MAX = 29;
   localparam int SIG_POS_W = $clog2(SIG_MAX);

   localparam logic [2:0] KIND_EXIF     = 3'd0;
   localparam logic [2:0] KIND_IPTC     = 3'd1;
   localparam logic [2:0] KIND_XMP      = 3'd2;
   localparam logic [2:0] KIND_FINISHED = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   localparam logic [1:0] CLS_EXIF = 2'd0;
   localparam logic [1:0] CLS_IPTC = 2'd1;
   localparam logic [1:0] CLS_XMP  = 2'd2;

   localparam logic [1:0] REG_EXIF_ENABLE = 2'd0;
   localparam logic [1:0] REG_IPTC_ENABLE = 2'd1;
   localparam logic [1:0] REG_XMP_ENABLE  = 2'd2;

   localparam logic [7:0] BYTE_PREFIX = 8'hFF;
   localparam logic [7:0] BYTE_SOI    = 8'hD8;
   localparam logic [7:0] BYTE_EOI    = 8'hD9;
   localparam logic [7:0] BYTE_SOS    = 8'hDA;
   localparam logic [7:0] BYTE_APP1   = 8'hE1;
   localparam logic [7:0] BYTE_APP13  = 8'hED;

   localparam logic [7:0] SIG_TAB [3][SIG_MAX] = '{
      '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h68, 8'h6F, 8'h74, 8'h6F, 8'h73, 8'h68, 8'h6F, 8'h70, 8'h20,
        8'h33, 8'h2E, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F, 8'h6E, 8'h73, 8'h2E,
        8'h61, 8'h64, 8'h6F, 8'h62, 8'h65, 8'h2E, 8'h63, 8'h6F, 8'h6D, 8'h2F,
        8'h78, 8'h61, 8'h70, 8'h2F, 8'h31, 8'h2E, 8'h30, 8'h2F, 8'h00}
   };

   typedef enum logic [10:0] {
      PH_SOI0    = 11'b000_0000_0001,
      PH_SOI1    = 11'b000_0000_0010,
      PH_MARK0   = 11'b000_0000_0100,
      PH_MARK1   = 11'b000_0000_1000,
      PH_LENHI   = 11'b000_0001_0000,
      PH_LENLO   = 11'b000_0010_0000,
      PH_SIG     = 11'b000_0100_0000,
      PH_CAPTURE = 11'b000_1000_0000,
      PH_SKIP    = 11'b001_0000_0000,
      PH_DONE    = 11'b010_0000_0000,
      PH_ERROR   = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] cls;
      logic [7:0] data;
      logic       last;
      logic       replay;
   } job_type;

   function automatic logic [SIG_POS_W-1:0] sig_len(input logic [1:0] cls);
      logic [SIG_POS_W-1:0] len;
      case (cls)
         CLS_EXIF: len = SIG_POS_W'(6);
         CLS_IPTC: len = SIG_POS_W'(14);
         CLS_XMP:  len = SIG_POS_W'(29);
         default:  len = '0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] sig_byte(input logic [1:0] cls,
                                           input logic [SIG_POS_W-1:0] pos);
      logic [7:0] val;
      val = 8'h00;
      if (cls != 2'd3 && pos < SIG_POS_W'(SIG_MAX)) begin
         val = SIG_TAB[cls][pos];
      end
      return val;
   endfunction

endpackage

[sv/jmse_req_if.sv]
// Interface of the byte input channel.
interface jmse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       new_image;

   modport source (output valid, output stream_byte, output new_image, input ready);
   modport sink (input valid, input stream_byte, input new_image, output ready);
endinterface

[sv/jmse_rsp_if.sv]
// Interface of the result output channel.
interface jmse_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] result_kind;
   logic [7:0] payload_byte;
   logic       segment_last;

   modport source (output valid, output result_kind, output payload_byte,
                   output segment_last, input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input segment_last, output ready);
endinterface

[sv/jmse_parser.sv]
// Marker and segment parser that turns each accepted byte into at most one result job.
module jmse_parser
   import jmse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   jmse_req_if.sink     req_ch,
   input  logic         csr_write_en,
   input  logic [1:0]   csr_index,
   input  logic         csr_write_data,
   input  logic         job_ready,
   output logic         job_valid,
   output job_type      job
);

   phase_type            phase_ff, phase_in, phase_eff;
   logic [7:0]           marker_ff, marker_in;
   logic [7:0]           len_high_ff, len_high_in;
   logic [15:0]          remain_ff, remain_in, remain_dec, seg_len;
   logic [SIG_POS_W-1:0] sig_pos_ff, sig_pos_in;
   logic [2:0]           cand_ff, cand_in, cand_new, hit, done;
   logic [1:0]           cls_ff, cls_in, cls_sel;
   logic                 exif_en_ff, iptc_en_ff, xmp_en_ff;
   logic                 accept, emit;
   logic [7:0]           b;

   assign req_ch.ready = job_ready;
   assign accept = req_ch.valid && job_ready;
   assign b = req_ch.stream_byte;
   assign job_valid = accept && emit;
   assign phase_eff = req_ch.new_image ? PH_SOI0 : phase_ff;
   assign remain_dec = (remain_ff != 16'd0) ? remain_ff - 16'd1 : remain_ff;
   assign seg_len = {len_high_ff, b};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         hit[c] = cand_ff[c] && (sig_pos_ff < sig_len(2'(c)))
                  && (b == sig_byte(2'(c), sig_pos_ff));
         done[c] = hit[c] && ((sig_pos_ff + SIG_POS_W'(1)) == sig_len(2'(c)));
      end
      cls_sel = done[0] ? CLS_EXIF : (done[1] ? CLS_IPTC : CLS_XMP);
      cand_new = 3'b000;
      if (marker_ff == BYTE_APP1 && seg_len >= 16'd8) begin
         cand_new[CLS_EXIF] = exif_en_ff;
         cand_new[CLS_XMP] = (seg_len >= 16'd31) && xmp_en_ff;
      end else if (marker_ff == BYTE_APP13 && seg_len >= 16'd16) begin
         cand_new[CLS_IPTC] = iptc_en_ff;
      end
   end

   always_comb begin
      phase_in = phase_eff;
      marker_in = marker_ff;
      len_high_in = len_high_ff;
      remain_in = remain_ff;
      sig_pos_in = sig_pos_ff;
      cand_in = cand_ff;
      cls_in = cls_ff;
      emit = 1'b0;
      job = '{kind: KIND_ERROR, cls: CLS_EXIF, data: 8'h00, last: 1'b0, replay: 1'b0};
      case (phase_eff)
         PH_SOI0: begin
            if (b != BYTE_PREFIX) begin
               phase_in = PH_ERROR;
               emit = 1'b1;
            end else begin
               phase_in = PH_SOI1;
            end
         end
         PH_SOI1: begin
            if (b != BYTE_SOI) begin
               phase_in = PH_ERROR;
               emit = 1'b1;
            end else begin
               phase_in = PH_MARK0;
            end
         end
         PH_MARK0: begin
            if (b != BYTE_PREFIX) begin
               phase_in = PH_ERROR;
               emit = 1'b1;
            end else begin
               phase_in = PH_MARK1;
            end
         end
         PH_MARK1: begin
            if (b == BYTE_EOI || b == BYTE_SOS) begin
               phase_in = PH_DONE;
               emit = 1'b1;
               job.kind = KIND_FINISHED;
            end else begin
               marker_in = b;
               phase_in = PH_LENHI;
            end
         end
         PH_LENHI: begin
            len_high_in = b;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            if (seg_len < 16'd2) begin
               phase_in = PH_ERROR;
               emit = 1'b1;
            end else begin
               remain_in = seg_len - 16'd2;
               sig_pos_in = '0;
               cand_in = cand_new;
               if (cand_new != 3'b000) begin
                  phase_in = PH_SIG;
               end else if (seg_len != 16'd2) begin
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_MARK0;
               end
            end
         end
         PH_SIG: begin
            remain_in = remain_dec;
            if (done != 3'b000) begin
               cls_in = cls_sel;
               cand_in = 3'b000;
               emit = 1'b1;
               job = '{kind: {1'b0, cls_sel}, cls: cls_sel, data: 8'h00,
                       last: (remain_dec == 16'd0), replay: 1'b1};
               phase_in = (remain_dec != 16'd0) ? PH_CAPTURE : PH_MARK0;
            end else if (hit == 3'b000 || remain_dec == 16'd0) begin
               cand_in = 3'b000;
               phase_in = (remain_dec != 16'd0) ? PH_SKIP : PH_MARK0;
            end else begin
               cand_in = hit;
               sig_pos_in = sig_pos_ff + SIG_POS_W'(1);
            end
         end
         PH_CAPTURE: begin
            remain_in = remain_dec;
            emit = 1'b1;
            job = '{kind: {1'b0, cls_ff}, cls: cls_ff, data: b,
                    last: (remain_dec == 16'd0), replay: 1'b0};
            if (remain_dec == 16'd0) begin
               phase_in = PH_MARK0;
            end
         end
         PH_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == 16'd0) begin
               phase_in = PH_MARK0;
            end
         end
         PH_DONE, PH_ERROR: begin
            phase_in = phase_eff;
         end
         default: begin
            phase_in = PH_ERROR;
            emit = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SOI0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         marker_ff <= marker_in;
         len_high_ff <= len_high_in;
         remain_ff <= remain_in;
         sig_pos_ff <= sig_pos_in;
         cand_ff <= cand_in;
         cls_ff <= cls_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exif_en_ff <= 1'b1;
         iptc_en_ff <= 1'b1;
         xmp_en_ff <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_EXIF_ENABLE: exif_en_ff <= csr_write_data;
            REG_IPTC_ENABLE: iptc_en_ff <= csr_write_data;
            REG_XMP_ENABLE:  xmp_en_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

endmodule

[sv/jmse_emitter.sv]
// Result register that presents single results and replays matched signatures byte by byte.
module jmse_emitter
   import jmse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  job_type      job,
   output logic         job_ready,
   jmse_rsp_if.source   rsp_ch
);

   logic                 out_valid_ff;
   job_type              job_ff;
   logic [SIG_POS_W-1:0] idx_ff;
   logic                 idx_last, finishing;

   assign idx_last = (idx_ff == (sig_len(job_ff.cls) - SIG_POS_W'(1)));
   assign finishing = !job_ff.replay || idx_last;
   assign job_ready = !out_valid_ff || (rsp_ch.ready && finishing);

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.result_kind = job_ff.kind;
   assign rsp_ch.payload_byte = job_ff.replay ? sig_byte(job_ff.cls, idx_ff) : job_ff.data;
   assign rsp_ch.segment_last = job_ff.replay ? (job_ff.last && idx_last) : job_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (job_valid && job_ready) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready && finishing) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         job_ff <= job;
         idx_ff <= '0;
      end else if (out_valid_ff && rsp_ch.ready && !finishing) begin
         idx_ff <= idx_ff + SIG_POS_W'(1);
      end
   end

endmodule

[sv/jpeg_metadata_segment_extractor_unit.sv]
// Top level of the JPEG metadata segment extractor.
// A byte's result is presented on the result channel in the cycle after its transfer.
// Throughput is one byte per cycle while the result channel is ready and nothing is
// replayed; the single result register sets that figure. A signature match replays
// 6, 14 or 29 results, one per cycle when ready, stalling input until the last is presented.
// Synchronous reset sets the parser to expect the start marker and all enables to one.
module jpeg_metadata_segment_extractor_unit
   import jmse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   jmse_req_if.sink     req_ch,
   jmse_rsp_if.source   rsp_ch,
   input  logic         csr_write_en,
   input  logic [1:0]   csr_index,
   input  logic         csr_write_data
);

   logic    job_valid, job_ready;
   job_type job;

   jmse_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .job_ready      (job_ready),
      .job_valid      (job_valid),
      .job            (job)
   );

   jmse_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.result_kind <= KIND_ERROR))
      else $error("Result kind out of range.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.result_kind == KIND_FINISHED ||
                        rsp_ch.result_kind == KIND_ERROR))
      |-> (rsp_ch.payload_byte == 8'h00 && !rsp_ch.segment_last))
      else $error("Finished or error result carries payload.");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid |-> req_ch.ready)
      else $error("Input stalled while the result register is empty.");
`endif

endmodule
